[hw/rtl/rlbpe_pkg.sv]
// shared types, constants and helpers for the rgb led blink pattern engine
package rlbpe_pkg;

  localparam int unsigned LED_COUNT      = 2;
  localparam int unsigned PATTERN_PHASES = 8;

  localparam int unsigned PHASE_W   = $clog2(PATTERN_PHASES);
  localparam int unsigned PERIOD_W  = 16;
  localparam int unsigned MODE_W    = 4;
  localparam int unsigned SEL_W     = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned PIN_W     = 3;

  // led count widened by one bit so a select can be compared against it
  localparam logic [SEL_W:0] LED_COUNT_VAL = (SEL_W + 1)'(LED_COUNT);
  localparam logic [PHASE_W-1:0] LAST_PHASE = PHASE_W'(PATTERN_PHASES - 1);

  localparam logic [PERIOD_W-1:0] NORMAL_PERIOD_RST = 16'd500;
  localparam logic [PERIOD_W-1:0] DOUBLE_PERIOD_RST = 16'd200;
  localparam logic [PERIOD_W-1:0] SLOW_PERIOD_RST   = 16'd1000;
  localparam logic [PERIOD_W-1:0] FAST_PERIOD_RST   = 16'd150;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_SET  = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NORMAL_PERIOD = 2'd0,
    REG_DOUBLE_PERIOD = 2'd1,
    REG_SLOW_PERIOD   = 2'd2,
    REG_FAST_PERIOD   = 2'd3
  } reg_idx_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_OFF          = 4'd0,
    MODE_RED          = 4'd1,
    MODE_GREEN        = 4'd2,
    MODE_WHITE        = 4'd3,
    MODE_PURPLE       = 4'd4,
    MODE_RED_BLINK    = 4'd5,
    MODE_DOUBLE       = 4'd6,
    MODE_SLOW         = 4'd7,
    MODE_FAST         = 4'd8,
    MODE_YELLOW_BLINK = 4'd9,
    MODE_WHITE_BLINK  = 4'd10,
    MODE_BLUE_BLINK   = 4'd11,
    MODE_CYAN_BLINK   = 4'd12
  } mode_t;

  // pin bits: 2 red, 1 green, 0 blue
  localparam logic [PIN_W-1:0] PINS_OFF    = 3'b000;
  localparam logic [PIN_W-1:0] PINS_RED    = 3'b100;
  localparam logic [PIN_W-1:0] PINS_GREEN  = 3'b010;
  localparam logic [PIN_W-1:0] PINS_BLUE   = 3'b001;
  localparam logic [PIN_W-1:0] PINS_YELLOW = 3'b110;
  localparam logic [PIN_W-1:0] PINS_PURPLE = 3'b101;
  localparam logic [PIN_W-1:0] PINS_CYAN   = 3'b011;
  localparam logic [PIN_W-1:0] PINS_WHITE  = 3'b111;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [PHASE_W-1:0]  phase;
    logic [PERIOD_W-1:0] elapsed;
    logic                running;
    logic [PIN_W-1:0]    pins;
  } led_slot_t;

  function automatic logic [PIN_W-1:0] colour_of(input logic [MODE_W-1:0] mode);
    logic [PIN_W-1:0] c;
    case (mode)
      MODE_OFF:          c = PINS_OFF;
      MODE_RED:          c = PINS_RED;
      MODE_GREEN:        c = PINS_GREEN;
      MODE_WHITE:        c = PINS_WHITE;
      MODE_PURPLE:       c = PINS_PURPLE;
      MODE_RED_BLINK:    c = PINS_RED;
      MODE_DOUBLE:       c = PINS_RED;
      MODE_SLOW:         c = PINS_RED;
      MODE_FAST:         c = PINS_RED;
      MODE_YELLOW_BLINK: c = PINS_YELLOW;
      MODE_WHITE_BLINK:  c = PINS_WHITE;
      MODE_BLUE_BLINK:   c = PINS_BLUE;
      MODE_CYAN_BLINK:   c = PINS_CYAN;
      default:           c = PINS_OFF;
    endcase
    return c;
  endfunction

endpackage

[hw/rtl/rlbpe_cmd_if.sv]
// command channel: tick or set led mode
interface rlbpe_cmd_if;
  logic                           valid;
  logic                           ready;
  logic                           operation;
  logic [rlbpe_pkg::SEL_W-1:0]    led_select;
  logic [rlbpe_pkg::MODE_W-1:0]   mode_code;

  modport source (output valid, operation, led_select, mode_code, input ready);
  modport sink (input valid, operation, led_select, mode_code, output ready);
endinterface

[hw/rtl/rlbpe_res_if.sv]
// result channel: pin levels of both leds and status
interface rlbpe_res_if;
  logic valid;
  logic ready;
  logic led0_red;
  logic led0_green;
  logic led0_blue;
  logic led1_red;
  logic led1_green;
  logic led1_blue;
  logic status;

  modport source (output valid, led0_red, led0_green, led0_blue,
                  led1_red, led1_green, led1_blue, status, input ready);
  modport sink (input valid, led0_red, led0_green, led0_blue,
                led1_red, led1_green, led1_blue, status, output ready);
endinterface

[hw/rtl/rlbpe_cfg_if.sv]
// configuration write channel: register index and write data
interface rlbpe_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [rlbpe_pkg::CFG_IDX_W-1:0]   index;
  logic [rlbpe_pkg::PERIOD_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/rgb_led_blink_pattern_engine.sv]
// rgb led blink pattern engine top level
//
// cmd carries one item per transfer: a 1 ms tick (operation 0) or a set command
// (operation 1) that gives an led number and a display mode. every command
// transfer yields exactly one transfer on result, with the pin levels of both
// leds after the command and a status bit (1 = led number out of range).
// cfg writes the four period registers (normal, double, slow, fast), index
// 0 to 3; it is always ready and should only be used while the block is idle.
// the led state updates at the command transfer and the result register holds the
// outcome from the next cycle on. one command is taken every cycle while result
// is not stalled; the per-led counter update and the result register are the
// only stages.
// the result register sits between the channels: while result is stalled it
// holds its item and cmd.ready drops, so no item is lost or repeated; once
// result.ready returns, a new command can be taken in that same cycle.
// reset (rst, synchronous) turns all leds off, stops blinking, empties the
// result register and loads the period registers with 500, 200, 1000, 150 ms.
module rgb_led_blink_pattern_engine (
  input  logic             clk,
  input  logic             rst,
  rlbpe_cmd_if.sink        cmd,
  rlbpe_res_if.source      result,
  rlbpe_cfg_if.sink        cfg
);

  logic [rlbpe_pkg::PERIOD_W-1:0] normal_period;
  logic [rlbpe_pkg::PERIOD_W-1:0] double_period;
  logic [rlbpe_pkg::PERIOD_W-1:0] slow_period;
  logic [rlbpe_pkg::PERIOD_W-1:0] fast_period;

  rlbpe_pkg::led_slot_t led_state      [rlbpe_pkg::LED_COUNT];
  rlbpe_pkg::led_slot_t led_state_next [rlbpe_pkg::LED_COUNT];

  logic                          res_valid;
  logic [rlbpe_pkg::PIN_W-1:0]   res_pins0;
  logic [rlbpe_pkg::PIN_W-1:0]   res_pins1;
  logic                          res_status;

  logic                          cmd_fire;
  logic                          sel_invalid;
  logic [rlbpe_pkg::PIN_W-1:0]   pins1_next;

  assign cfg.ready   = 1'b1;
  assign cmd.ready   = !res_valid || result.ready;
  assign cmd_fire    = cmd.valid && cmd.ready;
  assign sel_invalid = {1'b0, cmd.led_select} >= rlbpe_pkg::LED_COUNT_VAL;

  always_ff @(posedge clk) begin
    if (rst) begin
      normal_period <= rlbpe_pkg::NORMAL_PERIOD_RST;
      double_period <= rlbpe_pkg::DOUBLE_PERIOD_RST;
      slow_period   <= rlbpe_pkg::SLOW_PERIOD_RST;
      fast_period   <= rlbpe_pkg::FAST_PERIOD_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        rlbpe_pkg::REG_NORMAL_PERIOD: normal_period <= cfg.data;
        rlbpe_pkg::REG_DOUBLE_PERIOD: double_period <= cfg.data;
        rlbpe_pkg::REG_SLOW_PERIOD:   slow_period   <= cfg.data;
        rlbpe_pkg::REG_FAST_PERIOD:   fast_period   <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < rlbpe_pkg::LED_COUNT; i++) begin
      logic [rlbpe_pkg::PERIOD_W-1:0] period;
      logic [rlbpe_pkg::PERIOD_W:0]   elapsed_inc;
      logic [rlbpe_pkg::PIN_W-1:0]    colour;
      logic [rlbpe_pkg::PHASE_W-1:0]  p;
      led_state_next[i] = led_state[i];
      case (led_state[i].mode)
        rlbpe_pkg::MODE_DOUBLE: period = double_period;
        rlbpe_pkg::MODE_SLOW:   period = slow_period;
        rlbpe_pkg::MODE_FAST:   period = fast_period;
        default:                period = normal_period;
      endcase
      elapsed_inc = {1'b0, led_state[i].elapsed} + 1'b1;
      colour      = rlbpe_pkg::colour_of(led_state[i].mode);
      p           = led_state[i].phase;
      if (cmd.operation == rlbpe_pkg::OP_SET) begin
        if (cmd.led_select == rlbpe_pkg::SEL_W'(i)) begin
          led_state_next[i].running = 1'b0;
          led_state_next[i].mode    = cmd.mode_code;
          led_state_next[i].phase   = '0;
          if (cmd.mode_code <= rlbpe_pkg::MODE_PURPLE) begin
            led_state_next[i].pins = rlbpe_pkg::colour_of(cmd.mode_code);
          end else if (cmd.mode_code <= rlbpe_pkg::MODE_CYAN_BLINK) begin
            led_state_next[i].pins    = rlbpe_pkg::colour_of(cmd.mode_code);
            led_state_next[i].phase   = rlbpe_pkg::PHASE_W'(1);
            led_state_next[i].elapsed = '0;
            led_state_next[i].running = 1'b1;
          end
        end
      end else if (led_state[i].running) begin
        // a period of zero behaves like one since the increment is never zero
        if (elapsed_inc >= {1'b0, period}) begin
          led_state_next[i].elapsed = '0;
          if (led_state[i].mode == rlbpe_pkg::MODE_DOUBLE) begin
            led_state_next[i].pins  = (p == rlbpe_pkg::PHASE_W'(0) ||
                                       p == rlbpe_pkg::PHASE_W'(2)) ? colour
                                                                    : rlbpe_pkg::PINS_OFF;
            led_state_next[i].phase = (p == rlbpe_pkg::LAST_PHASE) ? '0 : p + 1'b1;
          end else if (p != '0) begin
            led_state_next[i].phase = '0;
            led_state_next[i].pins  = rlbpe_pkg::PINS_OFF;
          end else begin
            led_state_next[i].phase = rlbpe_pkg::PHASE_W'(1);
            led_state_next[i].pins  = colour;
          end
        end else begin
          led_state_next[i].elapsed = elapsed_inc[rlbpe_pkg::PERIOD_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < rlbpe_pkg::LED_COUNT; i++) begin
      if (rst) begin
        led_state[i] <= '0;
      end else if (cmd_fire) begin
        led_state[i] <= led_state_next[i];
      end
    end
  end

  // a missing second led reads as off
  generate
    if (rlbpe_pkg::LED_COUNT > 1) begin : g_led1
      assign pins1_next = led_state_next[1].pins;
    end else begin : g_no_led1
      assign pins1_next = rlbpe_pkg::PINS_OFF;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd_fire) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
    if (cmd_fire) begin
      res_pins0  <= led_state_next[0].pins;
      res_pins1  <= pins1_next;
      res_status <= (cmd.operation == rlbpe_pkg::OP_SET) && sel_invalid;
    end
  end

  assign result.valid      = res_valid;
  assign result.led0_red   = res_pins0[2];
  assign result.led0_green = res_pins0[1];
  assign result.led0_blue  = res_pins0[0];
  assign result.led1_red   = res_pins1[2];
  assign result.led1_green = res_pins1[1];
  assign result.led1_blue  = res_pins1[0];
  assign result.status     = res_status;

endmodule

[hw/rtl/rlbpe_checker.sv]
// port level checks for the rgb led blink pattern engine, with its bind
module rlbpe_checker (
  input logic clk,
  input logic rst,
  input logic cmd_valid,
  input logic cmd_ready,
  input logic cmd_operation,
  input logic res_valid,
  input logic res_ready,
  input logic res_status,
  input logic res_led0_red,
  input logic res_led1_red
);

  logic cmd_xfer;
  assign cmd_xfer = cmd_valid && cmd_ready;

  // every command transfer shows a result on the next cycle
  a_cmd_gives_result: assert property (@(posedge clk) disable iff (rst)
    cmd_xfer |=> res_valid)
    else $error("command transfer without a following result");

  // no command is taken while a result waits
  a_stall_blocks_cmd: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |-> !cmd_ready)
    else $error("command taken while result stalled");

  // a tick never reports an error
  a_tick_status: assert property (@(posedge clk) disable iff (rst)
    (cmd_xfer && cmd_operation == 1'b0) |=> !res_status)
    else $error("tick reported invalid status");

  a_res_valid_holds: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> res_valid)
    else $error("result dropped while stalled");

  a_res_payload_holds: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=>
      ($stable(res_status) && $stable(res_led0_red) && $stable(res_led1_red)))
    else $error("result payload changed while stalled");

endmodule

bind rgb_led_blink_pattern_engine rlbpe_checker u_rlbpe_checker (
  .clk           (clk),
  .rst           (rst),
  .cmd_valid     (cmd.valid),
  .cmd_ready     (cmd.ready),
  .cmd_operation (cmd.operation),
  .res_valid     (result.valid),
  .res_ready     (result.ready),
  .res_status    (result.status),
  .res_led0_red  (result.led0_red),
  .res_led1_red  (result.led1_red)
);

[sim/testbench.sv]
// self-checking testbench for the rgb led blink pattern engine
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam logic [rlbpe_pkg::MODE_W-1:0] MODE_FIRST_UNKNOWN =
    rlbpe_pkg::MODE_W'(rlbpe_pkg::MODE_CYAN_BLINK + 1);
  localparam logic [rlbpe_pkg::MODE_W-1:0] MODE_CODE_MAX = '1;
  localparam logic [rlbpe_pkg::PERIOD_W-1:0] PERIOD_MAX = '1;

  typedef struct packed {
    logic                         op;
    logic [rlbpe_pkg::SEL_W-1:0]  sel;
    logic [rlbpe_pkg::MODE_W-1:0] code;
  } lamp_cmd_t;

  typedef struct packed {
    logic [rlbpe_pkg::PIN_W-1:0] pins0;
    logic [rlbpe_pkg::PIN_W-1:0] pins1;
    logic                        status;
  } lamp_result_t;

  logic clk;
  logic rst;

  rlbpe_cmd_if cmd_bus ();
  rlbpe_res_if result_bus ();
  rlbpe_cfg_if cfg_bus ();

  rgb_led_blink_pattern_engine DUT (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd_bus),
    .result (result_bus),
    .cfg    (cfg_bus)
  );

  // predicted led state and period registers
  logic [rlbpe_pkg::PERIOD_W-1:0] period_reg [4];
  logic [rlbpe_pkg::MODE_W-1:0]   lamp_mode [rlbpe_pkg::LED_COUNT];
  logic [rlbpe_pkg::PHASE_W-1:0]  lamp_phase [rlbpe_pkg::LED_COUNT];
  logic [rlbpe_pkg::PERIOD_W-1:0] lamp_elapsed [rlbpe_pkg::LED_COUNT];
  logic                           lamp_running [rlbpe_pkg::LED_COUNT];
  logic [rlbpe_pkg::PIN_W-1:0]    lamp_pins [rlbpe_pkg::LED_COUNT];

  lamp_cmd_t    lamp_cmds_pending [$];
  lamp_result_t lamp_results_due [$];

  int n_errors;
  int n_results;
  int n_cycles;
  int burst_left;
  int gap_left;
  int hold_left;
  int rx_style;
  int rx_left;
  lamp_cmd_t cmd_now;
  lamp_result_t seen;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [rlbpe_pkg::PIN_W-1:0] hue_of(
    input logic [rlbpe_pkg::MODE_W-1:0] code);
    case (code)
      rlbpe_pkg::MODE_RED, rlbpe_pkg::MODE_RED_BLINK, rlbpe_pkg::MODE_DOUBLE,
      rlbpe_pkg::MODE_SLOW, rlbpe_pkg::MODE_FAST:  return rlbpe_pkg::PINS_RED;
      rlbpe_pkg::MODE_GREEN:                       return rlbpe_pkg::PINS_GREEN;
      rlbpe_pkg::MODE_WHITE, rlbpe_pkg::MODE_WHITE_BLINK:
                                                   return rlbpe_pkg::PINS_WHITE;
      rlbpe_pkg::MODE_PURPLE:                      return rlbpe_pkg::PINS_PURPLE;
      rlbpe_pkg::MODE_YELLOW_BLINK:                return rlbpe_pkg::PINS_YELLOW;
      rlbpe_pkg::MODE_BLUE_BLINK:                  return rlbpe_pkg::PINS_BLUE;
      rlbpe_pkg::MODE_CYAN_BLINK:                  return rlbpe_pkg::PINS_CYAN;
      default:                                     return rlbpe_pkg::PINS_OFF;
    endcase
  endfunction

  // updates the predicted state for one accepted command, returns the pin levels
  function automatic lamp_result_t advance_lamps(input logic op,
                                                 input logic [rlbpe_pkg::SEL_W-1:0] sel,
                                                 input logic [rlbpe_pkg::MODE_W-1:0] code);
    lamp_result_t r;
    logic [rlbpe_pkg::PERIOD_W:0] count;
    logic [rlbpe_pkg::PERIOD_W-1:0] span;
    logic [rlbpe_pkg::PHASE_W-1:0] p;
    r.status = 1'b0;
    if (op == rlbpe_pkg::OP_SET) begin
      if (sel >= rlbpe_pkg::LED_COUNT) begin
        r.status = 1'b1;
      end else begin
        lamp_running[sel] = 1'b0;
        lamp_mode[sel] = code;
        lamp_phase[sel] = '0;
        if (code <= rlbpe_pkg::MODE_PURPLE) begin
          lamp_pins[sel] = hue_of(code);
        end else if (code <= rlbpe_pkg::MODE_CYAN_BLINK) begin
          lamp_pins[sel] = hue_of(code);
          lamp_phase[sel] = rlbpe_pkg::PHASE_W'(1);
          lamp_elapsed[sel] = '0;
          lamp_running[sel] = 1'b1;
        end
        // unknown codes stop blinking but leave the pins alone
      end
    end else begin
      for (int i = 0; i < rlbpe_pkg::LED_COUNT; i++) begin
        if (lamp_running[i]) begin
          case (lamp_mode[i])
            rlbpe_pkg::MODE_DOUBLE: span = period_reg[rlbpe_pkg::REG_DOUBLE_PERIOD];
            rlbpe_pkg::MODE_SLOW:   span = period_reg[rlbpe_pkg::REG_SLOW_PERIOD];
            rlbpe_pkg::MODE_FAST:   span = period_reg[rlbpe_pkg::REG_FAST_PERIOD];
            default:                span = period_reg[rlbpe_pkg::REG_NORMAL_PERIOD];
          endcase
          count = lamp_elapsed[i] + 1'b1;
          // a zero period fires on every tick, a lowered one on the next tick
          if (count >= span) begin
            lamp_elapsed[i] = '0;
            if (lamp_mode[i] == rlbpe_pkg::MODE_DOUBLE) begin
              p = lamp_phase[i];
              lamp_pins[i] = (p == 0 || p == 2) ? hue_of(lamp_mode[i])
                                                : rlbpe_pkg::PINS_OFF;
              lamp_phase[i] = rlbpe_pkg::PHASE_W'((p + 1) % rlbpe_pkg::PATTERN_PHASES);
            end else begin
              lamp_phase[i] = (lamp_phase[i] != 0) ? rlbpe_pkg::PHASE_W'(0)
                                                   : rlbpe_pkg::PHASE_W'(1);
              lamp_pins[i] = (lamp_phase[i] != 0) ? hue_of(lamp_mode[i])
                                                  : rlbpe_pkg::PINS_OFF;
            end
          end else begin
            lamp_elapsed[i] = count[rlbpe_pkg::PERIOD_W-1:0];
          end
        end
      end
    end
    r.pins0 = lamp_pins[0];
    r.pins1 = lamp_pins[1];
    return r;
  endfunction

  task automatic check_bit(input string field, input logic exp, input logic act);
    if (exp !== act) begin
      $error("%s: expected %0b, got %0b", field, exp, act);
      n_errors++;
    end
  endtask

  task automatic queue_tick();
    lamp_cmd_t c;
    c.op = rlbpe_pkg::OP_TICK;
    c.sel = rlbpe_pkg::SEL_W'($urandom_range(0, 3));
    c.code = rlbpe_pkg::MODE_W'($urandom_range(0, 15));
    lamp_cmds_pending.push_back(c);
  endtask

  task automatic queue_set(input logic [rlbpe_pkg::SEL_W-1:0] sel,
                           input logic [rlbpe_pkg::MODE_W-1:0] code);
    lamp_cmd_t c;
    c.op = rlbpe_pkg::OP_SET;
    c.sel = sel;
    c.code = code;
    lamp_cmds_pending.push_back(c);
  endtask

  // mostly ticks so blink patterns get far; invalid led numbers are not counted
  task automatic queue_random(input int count);
    int n;
    logic [rlbpe_pkg::SEL_W-1:0] sel;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 99) < 75) begin
        queue_tick();
        n++;
      end else begin
        sel = ($urandom_range(0, 9) < 8) ? rlbpe_pkg::SEL_W'($urandom_range(0, 1))
                                         : rlbpe_pkg::SEL_W'($urandom_range(2, 3));
        if ($urandom_range(0, 3) == 0)
          queue_set(sel, rlbpe_pkg::MODE_DOUBLE);
        else
          queue_set(sel, rlbpe_pkg::MODE_W'($urandom_range(0, 15)));
        if (sel < rlbpe_pkg::LED_COUNT)
          n++;
      end
    end
  endtask

  task automatic wait_idle();
    while (lamp_cmds_pending.size() != 0 || cmd_bus.valid || lamp_results_due.size() != 0)
      @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_period(input rlbpe_pkg::reg_idx_t idx,
                              input logic [rlbpe_pkg::PERIOD_W-1:0] value);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    period_reg[idx] = value;
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic apply_periods(input logic [rlbpe_pkg::PERIOD_W-1:0] normal,
                               input logic [rlbpe_pkg::PERIOD_W-1:0] dbl,
                               input logic [rlbpe_pkg::PERIOD_W-1:0] slow,
                               input logic [rlbpe_pkg::PERIOD_W-1:0] fast);
    wait_idle();
    write_period(rlbpe_pkg::REG_NORMAL_PERIOD, normal);
    write_period(rlbpe_pkg::REG_DOUBLE_PERIOD, dbl);
    write_period(rlbpe_pkg::REG_SLOW_PERIOD, slow);
    write_period(rlbpe_pkg::REG_FAST_PERIOD, fast);
  endtask

  // sender: bursts of random length with random gaps
  always @(posedge clk) begin
    if (rst) begin
      cmd_bus.valid <= 1'b0;
      burst_left = $urandom_range(1, 24);
      gap_left = 0;
    end else begin
      if (cmd_bus.valid && cmd_bus.ready)
        lamp_results_due.push_back(advance_lamps(cmd_bus.operation, cmd_bus.led_select,
                                                 cmd_bus.mode_code));
      if (!cmd_bus.valid || cmd_bus.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          cmd_bus.valid <= 1'b0;
        end else if (lamp_cmds_pending.size() > 0) begin
          cmd_now = lamp_cmds_pending.pop_front();
          cmd_bus.valid <= 1'b1;
          cmd_bus.operation <= cmd_now.op;
          cmd_bus.led_select <= cmd_now.sel;
          cmd_bus.mode_code <= cmd_now.code;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          cmd_bus.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each transfer, stalls in stretches of its own
  always @(posedge clk) begin
    if (rst) begin
      result_bus.ready <= 1'b0;
      hold_left = 0;
      rx_left = 0;
      rx_style = 0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        if (lamp_results_due.size() == 0) begin
          $error("result transfer with nothing expected");
          n_errors++;
        end else begin
          seen = lamp_results_due.pop_front();
          check_bit("led0_red", seen.pins0[2], result_bus.led0_red);
          check_bit("led0_green", seen.pins0[1], result_bus.led0_green);
          check_bit("led0_blue", seen.pins0[0], result_bus.led0_blue);
          check_bit("led1_red", seen.pins1[2], result_bus.led1_red);
          check_bit("led1_green", seen.pins1[1], result_bus.led1_green);
          check_bit("led1_blue", seen.pins1[0], result_bus.led1_blue);
          check_bit("status", seen.status, result_bus.status);
        end
        n_results++;
        // long hold-off so the block fills up and stalls the command side
        if (n_results % 200 == 100)
          hold_left = 150;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_bus.ready <= 1'b0;
      end else begin
        if (rx_left <= 0) begin
          rx_style = $urandom_range(0, 2);
          rx_left = $urandom_range(4, 40);
        end
        rx_left--;
        case (rx_style)
          0:       result_bus.ready <= 1'b1;
          1:       result_bus.ready <= 1'($urandom_range(0, 1));
          default: result_bus.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cmd_bus.valid = 1'b0;
    cmd_bus.operation = rlbpe_pkg::OP_TICK;
    cmd_bus.led_select = '0;
    cmd_bus.mode_code = rlbpe_pkg::MODE_OFF;
    result_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = rlbpe_pkg::REG_NORMAL_PERIOD;
    cfg_bus.data = '0;
    n_errors = 0;
    n_results = 0;
    n_cycles = 0;
    period_reg[rlbpe_pkg::REG_NORMAL_PERIOD] = rlbpe_pkg::NORMAL_PERIOD_RST;
    period_reg[rlbpe_pkg::REG_DOUBLE_PERIOD] = rlbpe_pkg::DOUBLE_PERIOD_RST;
    period_reg[rlbpe_pkg::REG_SLOW_PERIOD] = rlbpe_pkg::SLOW_PERIOD_RST;
    period_reg[rlbpe_pkg::REG_FAST_PERIOD] = rlbpe_pkg::FAST_PERIOD_RST;
    for (int i = 0; i < rlbpe_pkg::LED_COUNT; i++) begin
      lamp_mode[i] = rlbpe_pkg::MODE_OFF;
      lamp_phase[i] = '0;
      lamp_elapsed[i] = '0;
      lamp_running[i] = 1'b0;
      lamp_pins[i] = rlbpe_pkg::PINS_OFF;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // every mode, unknown codes, invalid led numbers, with the reset periods
    queue_set(2'd0, rlbpe_pkg::MODE_OFF);
    queue_set(2'd0, rlbpe_pkg::MODE_RED);
    queue_set(2'd1, rlbpe_pkg::MODE_GREEN);
    queue_set(2'd0, rlbpe_pkg::MODE_WHITE);
    queue_set(2'd1, rlbpe_pkg::MODE_PURPLE);
    queue_set(2'd0, rlbpe_pkg::MODE_RED_BLINK);
    queue_tick();
    queue_set(2'd1, rlbpe_pkg::MODE_DOUBLE);
    queue_tick();
    queue_set(2'd0, rlbpe_pkg::MODE_SLOW);
    queue_set(2'd1, rlbpe_pkg::MODE_FAST);
    queue_set(2'd0, rlbpe_pkg::MODE_YELLOW_BLINK);
    queue_set(2'd1, rlbpe_pkg::MODE_WHITE_BLINK);
    queue_set(2'd0, rlbpe_pkg::MODE_BLUE_BLINK);
    queue_set(2'd1, rlbpe_pkg::MODE_CYAN_BLINK);
    queue_tick();
    queue_set(2'd0, MODE_FIRST_UNKNOWN);
    queue_set(2'd1, MODE_CODE_MAX);
    queue_set(2'd2, rlbpe_pkg::MODE_RED);
    queue_set(2'd3, MODE_CODE_MAX);
    queue_tick();

    apply_periods(16'd1, 16'd1, 16'd1, 16'd1);
    queue_random(70);
    apply_periods(16'd0, 16'd0, 16'd0, 16'd0);
    queue_random(50);
    apply_periods(rlbpe_pkg::PERIOD_W'($urandom_range(2, 9)),
                  rlbpe_pkg::PERIOD_W'($urandom_range(2, 9)),
                  rlbpe_pkg::PERIOD_W'($urandom_range(2, 9)),
                  rlbpe_pkg::PERIOD_W'($urandom_range(2, 9)));
    queue_random(80);
    apply_periods(PERIOD_MAX, PERIOD_MAX, PERIOD_MAX, PERIOD_MAX);
    queue_random(30);
    apply_periods(16'd40, 16'd40, 16'd40, 16'd40);
    queue_random(60);
    queue_set(2'd0, rlbpe_pkg::MODE_SLOW);
    queue_set(2'd1, rlbpe_pkg::MODE_DOUBLE);
    repeat (10) queue_tick();
    // lower the periods under the running counts
    apply_periods(16'd3, 16'd2, 16'd4, 16'd1);
    repeat (5) queue_tick();
    queue_random(60);
    apply_periods(rlbpe_pkg::PERIOD_W'($urandom_range(1, 16)),
                  rlbpe_pkg::PERIOD_W'($urandom_range(1, 16)),
                  rlbpe_pkg::PERIOD_W'($urandom_range(1, 16)),
                  rlbpe_pkg::PERIOD_W'($urandom_range(1, 16)));
    queue_random(80);
    apply_periods(rlbpe_pkg::PERIOD_W'($urandom_range(1, 6)),
                  rlbpe_pkg::PERIOD_W'($urandom_range(1, 6)),
                  rlbpe_pkg::PERIOD_W'($urandom_range(1, 6)),
                  rlbpe_pkg::PERIOD_W'($urandom_range(1, 6)));
    queue_random(70);

    wait_idle();
    repeat (5) @(posedge clk);
    if (n_errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/rlbpe_pkg.sv
hw/rtl/rlbpe_cmd_if.sv
hw/rtl/rlbpe_res_if.sv
hw/rtl/rlbpe_cfg_if.sv
hw/rtl/rgb_led_blink_pattern_engine.sv
hw/rtl/rlbpe_checker.sv
sim/testbench.sv
